// ----- hdl/balance_line_follow_controller_macros.svh -----
// assertion macros for the balance line follow controller
// no dependencies; included by the top level only
`ifndef BALANCE_LINE_FOLLOW_CONTROLLER_MACROS_SVH
`define BALANCE_LINE_FOLLOW_CONTROLLER_MACROS_SVH

// antecedent holds now, consequent holds in the same cycle
`define BLFC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// antecedent holds now, consequent holds in the next cycle
`define BLFC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/blfc_pkg.sv -----
// shared widths, constants, types and helpers of the balance line follow controller
// no dependencies; used by the top level, blfc_div and blfc_mul
`default_nettype none
package blfc_pkg;
	localparam int SENS_W    = 12;
	localparam int MAP_W     = 10;
	localparam int PITCH_W   = 16;
	localparam int PSUM_W    = 19;
	localparam int PDIFF_W   = 17;
	localparam int POS_W     = 11;
	localparam int ERR_W     = 15;
	localparam int YSUM_W    = 14;
	localparam int YDIFF_W   = 16;
	localparam int GAIN_W    = 16;
	localparam int MUL_A_W   = 17;
	localparam int MUL_B_W   = 20;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int ACC_W     = 40;
	localparam int CORR_W    = 32;
	localparam int ABSC_W    = 15;
	localparam int DUTY_W    = 7;
	localparam int DIV_NUM_W = 22;
	localparam int DIV_DEN_W = 12;

	// sensor mapping and line position
	localparam int MAP_LO      = 1700;
	localparam int MAP_SCALE   = 1000;
	localparam int LOST_THRESH = 400;
	localparam int LOST_POS    = 640;

	// offset * 1000 / 2300 is offset * 10 / 23: reciprocal 10 * ceil(2^24 / 23),
	// exact for every offset a 12-bit reading can give
	localparam int MAP_RECIP   = 7294450;
	localparam int MAP_SHIFT   = 24;
	localparam int MAP_PROD_W  = 35;

	// clamps and thresholds, q8.8
	localparam int PSUM_LIM    = 850 * 256;
	localparam int YSUM_LIM    = 30 * 256;
	localparam int CORR_LIM    = 90 * 256;
	localparam int DUTY_LO     = 60 * 256;
	localparam int DUTY_HI     = 100 * 256;
	localparam int TURN_THRESH = 2560;
	localparam int TURN_BOOST  = 15;
	localparam int LEVEL_BAND  = 256;
	localparam int FALL_LIMIT  = -640;

	// yaw integral gain, unsigned q8.8
	localparam logic [GAIN_W-1:0] YAW_KI_Q8 = 16'd0;

	// drive direction codes
	localparam logic [1:0] DIR_FWD  = 2'd0;
	localparam logic [1:0] DIR_BACK = 2'd1;
	localparam logic [1:0] DIR_STOP = 2'd2;

	// register indexes
	localparam logic [2:0] REG_PITCH_KP  = 3'd0;
	localparam logic [2:0] REG_PITCH_KI  = 3'd1;
	localparam logic [2:0] REG_PITCH_KD  = 3'd2;
	localparam logic [2:0] REG_YAW_KP    = 3'd3;
	localparam logic [2:0] REG_YAW_KD    = 3'd4;
	localparam logic [2:0] REG_SETPOINT  = 3'd5;
	localparam logic [2:0] REG_FWD_OFF   = 3'd6;
	localparam logic [2:0] REG_FWD_LIMIT = 3'd7;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	// q16.16 to q8.8, truncating toward zero
	function automatic logic signed [ACC_W-1:0] q_trunc(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] mag;
		mag = v[ACC_W-1] ? -v : v;
		mag = mag >>> 8;
		return v[ACC_W-1] ? -mag : mag;
	endfunction

	// clamp to 60..100 percent and drop the fraction
	function automatic logic [DUTY_W-1:0] duty_of(input logic signed [CORR_W+1:0] v);
		if (v < DUTY_LO)
			return DUTY_W'(60);
		else if (v > DUTY_HI)
			return DUTY_W'(100);
		else
			return v[DUTY_W+7:8];
	endfunction
endpackage
`default_nettype wire

// ----- hdl/balance_line_follow_controller.sv -----
// balance line follow controller top level: sequencer, state and register file
// depends on blfc_pkg, blfc_div, blfc_mul and balance_line_follow_controller_macros.svh
//
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    s_tdata: pitch_in, sensor_a..sensor_d
// m_        out  m_tvalid/m_tready    m_tdata: left, right, direction, reference, balanced
// apb       in   psel/penable/pready  eight 16-bit registers at 4*i
//
// after the input transfer the sequencer maps the sensors one by one, divides out the line
// position, updates the yaw state, forms the products and truncates the corrections; the
// divide is skipped when the line is lost; the next input can be taken once the result is
// valid, and the input is ready only while the sequencer is idle
// a finished result waits in the output register and the sequencer holds in its last
// step until that register is free; reset clears the loop state and loads the default gains
`default_nettype none
`include "balance_line_follow_controller_macros.svh"
module balance_line_follow_controller #(
	parameter logic [blfc_pkg::GAIN_W-1:0] YAW_KI = blfc_pkg::YAW_KI_Q8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// pitch_in[15:0], sensor_a[27:16], sensor_b[39:28], sensor_c[51:40], sensor_d[63:52]
	input  wire logic [63:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// left_drive[6:0], right_drive[13:7], direction[15:14], angle_reference[31:16],
	// is_balanced[32], zero[39:33]
	output logic [39:0]      m_tdata,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import blfc_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MAP   = 4'd1;
	localparam logic [3:0] ST_POS   = 4'd3;
	localparam logic [3:0] ST_POSW  = 4'd4;
	localparam logic [3:0] ST_YAW   = 4'd5;
	localparam logic [3:0] ST_MUL   = 4'd6;
	localparam logic [3:0] ST_TRUNC = 4'd7;
	localparam logic [3:0] ST_FIN   = 4'd8;

	// registers
	logic [GAIN_W-1:0]         pitch_kp_q, pitch_ki_q, pitch_kd_q, yaw_kp_q, yaw_kd_q;
	logic signed [PITCH_W-1:0] setpoint_q, fwd_off_q, fwd_limit_q;

	// loop state
	logic                      mode_q;
	logic signed [PITCH_W-1:0] held_ref_q, drive_angle_q, pitch_prev_q;
	logic signed [PSUM_W-1:0]  pitch_sum_q;
	logic signed [ERR_W-1:0]   yaw_prev_q;
	logic signed [YSUM_W-1:0]  yaw_sum_q;

	// per-transfer working registers
	logic [3:0]                state_q;
	logic [1:0]                idx_q;
	logic [2:0]                mul_cnt_q;
	logic signed [PITCH_W-1:0] pitch_q;
	logic [SENS_W-1:0]         sens_q [4];
	logic [MAP_W-1:0]          map_q [4];
	logic signed [PDIFF_W-1:0] pdiff_q;
	logic                      neg_q;
	logic signed [POS_W-1:0]   pos_q;
	logic signed [ERR_W-1:0]   e_q;
	logic signed [YDIFF_W-1:0] ydiff_q;
	logic signed [ACC_W-1:0]   pacc_q, yacc_q;
	logic [ABSC_W-1:0]         absc_q;
	logic signed [CORR_W-1:0]  ycorr_q;

	// output register
	logic                      out_valid_q;
	logic [DUTY_W-1:0]         out_left_q, out_right_q;
	logic [1:0]                out_dir_q;
	logic signed [PITCH_W-1:0] out_ref_q;
	logic                      out_bal_q;

	// shared units
	div_req_t                  div_req;
	logic                      div_done;
	logic [DIV_NUM_W-1:0]      div_quot;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_prod;

	blfc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	blfc_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (mul_prod)
	);

	logic                      cfg_wr;
	logic [2:0]                cfg_idx;
	logic                      in_xfer;
	logic                      out_xfer;
	logic                      out_free;

	assign cfg_wr   = psel && penable && pwrite;
	assign cfg_idx  = paddr[4:2];
	assign pready   = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = out_valid_q && m_tready;
	assign out_free = !out_valid_q || m_tready;

	// register read
	always_comb begin
		unique case (cfg_idx)
			REG_PITCH_KP:  prdata = {16'd0, pitch_kp_q};
			REG_PITCH_KI:  prdata = {16'd0, pitch_ki_q};
			REG_PITCH_KD:  prdata = {16'd0, pitch_kd_q};
			REG_YAW_KP:    prdata = {16'd0, yaw_kp_q};
			REG_YAW_KD:    prdata = {16'd0, yaw_kd_q};
			REG_SETPOINT:  prdata = {{16{setpoint_q[15]}}, setpoint_q};
			REG_FWD_OFF:   prdata = {{16{fwd_off_q[15]}}, fwd_off_q};
			REG_FWD_LIMIT: prdata = {{16{fwd_limit_q[15]}}, fwd_limit_q};
			default:       prdata = 32'd0;
		endcase
	end

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_kp_q  <= 16'd3866;
			pitch_ki_q  <= 16'd19;
			pitch_kd_q  <= 16'd2304;
			yaw_kp_q    <= 16'd1434;
			yaw_kd_q    <= 16'd435;
			setpoint_q  <= -16'sd1280;
			fwd_off_q   <= 16'sd64;
			fwd_limit_q <= 16'sd768;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_PITCH_KP:  pitch_kp_q  <= pwdata[15:0];
				REG_PITCH_KI:  pitch_ki_q  <= pwdata[15:0];
				REG_PITCH_KD:  pitch_kd_q  <= pwdata[15:0];
				REG_YAW_KP:    yaw_kp_q    <= pwdata[15:0];
				REG_YAW_KD:    yaw_kd_q    <= pwdata[15:0];
				REG_SETPOINT:  setpoint_q  <= pwdata[15:0];
				REG_FWD_OFF:   fwd_off_q   <= pwdata[15:0];
				REG_FWD_LIMIT: fwd_limit_q <= pwdata[15:0];
				default:       ;
			endcase
		end
	end

	// pitch integral on the incoming sample
	logic signed [PITCH_W-1:0] in_pitch;
	logic signed [PSUM_W:0]    psum_ext;
	logic signed [PSUM_W-1:0]  psum_next;
	always_comb begin
		in_pitch = s_tdata[15:0];
		psum_ext = {pitch_sum_q[PSUM_W-1], pitch_sum_q}
			+ {{(PSUM_W+1-PITCH_W){in_pitch[PITCH_W-1]}}, in_pitch};
		if (psum_ext > PSUM_LIM)
			psum_next = PSUM_W'(PSUM_LIM);
		else if (psum_ext < -PSUM_LIM)
			psum_next = PSUM_W'(-PSUM_LIM);
		else
			psum_next = psum_ext[PSUM_W-1:0];
	end

	// sensor map by reciprocal multiplication, one sensor per cycle
	logic [SENS_W-1:0]     raw_sel;
	logic                  raw_low;
	logic [SENS_W-1:0]     map_off;
	logic [MAP_PROD_W-1:0] map_prod;
	logic [MAP_W:0]        map_quo;
	logic [MAP_W-1:0]      map_val;
	always_comb begin
		raw_sel  = sens_q[idx_q];
		raw_low  = raw_sel < SENS_W'(MAP_LO);
		map_off  = raw_sel - SENS_W'(MAP_LO);
		map_prod = MAP_PROD_W'(map_off) * MAP_PROD_W'(MAP_RECIP);
		map_quo  = map_prod[MAP_SHIFT +: (MAP_W+1)];
		if (raw_low)
			map_val = '0;
		else if (map_quo > (MAP_W+1)'(MAP_SCALE))
			map_val = MAP_W'(MAP_SCALE);
		else
			map_val = map_quo[MAP_W-1:0];
	end

	// centroid sums
	logic signed [13:0]    wsum;
	logic [SENS_W-1:0]     ssum;
	logic                  lost;
	logic [13:0]           wmag;
	always_comb begin
		wsum = 14'(3 * map_q[0]) + 14'(map_q[1]) - 14'(map_q[2]) - 14'(3 * map_q[3]);
		ssum = SENS_W'(map_q[0]) + SENS_W'(map_q[1]) + SENS_W'(map_q[2]) + SENS_W'(map_q[3]);
		lost = !((map_q[0] > MAP_W'(LOST_THRESH)) || (map_q[1] > MAP_W'(LOST_THRESH))
			|| (map_q[2] > MAP_W'(LOST_THRESH)) || (map_q[3] > MAP_W'(LOST_THRESH)));
		wmag = wsum[13] ? -wsum : wsum;
	end

	// divider request for the line position
	always_comb begin
		div_req = '0;
		if (state_q == ST_POS && !lost) begin
			div_req.start = 1'b1;
			div_req.num   = DIV_NUM_W'({wmag, 8'd0});
			div_req.den   = ssum;
		end
	end

	// yaw error and integral
	logic signed [ERR_W-1:0]   e_new;
	logic signed [YDIFF_W-1:0] ydiff_new;
	logic signed [ERR_W:0]     ysum_ext;
	logic signed [YSUM_W-1:0]  ysum_next;
	always_comb begin
		e_new     = ERR_W'(pos_q) * ERR_W'(10);
		ydiff_new = YDIFF_W'(e_new) - YDIFF_W'(yaw_prev_q);
		ysum_ext  = (ERR_W+1)'(yaw_sum_q) + (ERR_W+1)'(e_new);
		if (ysum_ext > YSUM_LIM)
			ysum_next = YSUM_W'(YSUM_LIM);
		else if (ysum_ext < -YSUM_LIM)
			ysum_next = YSUM_W'(-YSUM_LIM);
		else
			ysum_next = ysum_ext[YSUM_W-1:0];
	end

	// multiplier operand select
	always_comb begin
		case (mul_cnt_q)
			3'd0: begin
				mul_a = {1'b0, pitch_kp_q};
				mul_b = MUL_B_W'(pitch_q);
			end
			3'd1: begin
				mul_a = {1'b0, pitch_ki_q};
				mul_b = MUL_B_W'(pitch_sum_q);
			end
			3'd2: begin
				mul_a = {1'b0, pitch_kd_q};
				mul_b = MUL_B_W'(pdiff_q);
			end
			3'd3: begin
				mul_a = {1'b0, yaw_kp_q};
				mul_b = MUL_B_W'(e_q);
			end
			3'd4: begin
				mul_a = {1'b0, YAW_KI};
				mul_b = MUL_B_W'(yaw_sum_q);
			end
			default: begin
				mul_a = {1'b0, yaw_kd_q};
				mul_b = MUL_B_W'(ydiff_q);
			end
		endcase
	end

	// truncation of both corrections and magnitude of the pitch correction
	logic signed [ACC_W-1:0] pt, pabs, yt;
	always_comb begin
		pt   = q_trunc(pacc_q);
		pabs = pt[ACC_W-1] ? -pt : pt;
		yt   = q_trunc(yacc_q);
	end

	// final mixing
	logic signed [CORR_W+1:0]  rsum, lsum;
	logic [DUTY_W-1:0]         rd, ld, hold_d;
	logic signed [PITCH_W:0]   da_ext;
	logic signed [PITCH_W-1:0] da_sat;
	always_comb begin
		rsum   = (CORR_W+2)'(absc_q) + (CORR_W+2)'(ycorr_q);
		lsum   = (CORR_W+2)'(absc_q) - (CORR_W+2)'(ycorr_q);
		rd     = duty_of(rsum);
		ld     = duty_of(lsum);
		hold_d = duty_of((CORR_W+2)'(absc_q));
		if (e_q > TURN_THRESH) begin
			rd = rd + DUTY_W'(TURN_BOOST);
			ld = ld - DUTY_W'(TURN_BOOST);
		end else if (e_q < -TURN_THRESH) begin
			ld = ld + DUTY_W'(TURN_BOOST);
			rd = rd - DUTY_W'(TURN_BOOST);
		end
		da_ext = {setpoint_q[PITCH_W-1], setpoint_q} + {fwd_off_q[PITCH_W-1], fwd_off_q};
		if (da_ext > 32767)
			da_sat = 16'sh7fff;
		else if (da_ext < -32768)
			da_sat = -16'sh8000;
		else
			da_sat = da_ext[PITCH_W-1:0];
	end

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			idx_q         <= '0;
			mul_cnt_q     <= '0;
			mode_q        <= 1'b0;
			held_ref_q    <= '0;
			drive_angle_q <= '0;
			pitch_prev_q  <= '0;
			pitch_sum_q   <= '0;
			yaw_prev_q    <= '0;
			yaw_sum_q     <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_xfer)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						pitch_prev_q <= in_pitch;
						pitch_sum_q  <= psum_next;
						idx_q        <= '0;
						state_q      <= ST_MAP;
					end
				end
				ST_MAP: begin
					if (idx_q == 2'd3)
						state_q <= ST_POS;
					else
						idx_q <= idx_q + 1'b1;
				end
				ST_POS: begin
					state_q <= lost ? ST_YAW : ST_POSW;
				end
				ST_POSW: begin
					if (div_done)
						state_q <= ST_YAW;
				end
				ST_YAW: begin
					yaw_prev_q <= e_new;
					yaw_sum_q  <= ysum_next;
					mul_cnt_q  <= '0;
					state_q    <= ST_MUL;
				end
				ST_MUL: begin
					mul_cnt_q <= mul_cnt_q + 1'b1;
					if (mul_cnt_q == 3'd6)
						state_q <= ST_TRUNC;
				end
				ST_TRUNC: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (!mode_q) begin
							if (pitch_q <= LEVEL_BAND && pitch_q >= -LEVEL_BAND) begin
								held_ref_q <= drive_angle_q;
								mode_q     <= 1'b1;
							end else
								held_ref_q <= setpoint_q;
						end else begin
							drive_angle_q <= da_sat;
							if (pitch_q > fwd_limit_q || pitch_q < FALL_LIMIT) begin
								held_ref_q <= setpoint_q;
								mode_q     <= 1'b0;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pitch_q   <= in_pitch;
			pdiff_q   <= PDIFF_W'(in_pitch) - PDIFF_W'(pitch_prev_q);
			sens_q[0] <= s_tdata[27:16];
			sens_q[1] <= s_tdata[39:28];
			sens_q[2] <= s_tdata[51:40];
			sens_q[3] <= s_tdata[63:52];
		end
		if (state_q == ST_MAP)
			map_q[idx_q] <= map_val;
		if (state_q == ST_POS) begin
			neg_q <= wsum[13];
			if (lost)
				pos_q <= (yaw_prev_q > 0) ? POS_W'(LOST_POS) : -POS_W'(LOST_POS);
		end
		if (state_q == ST_POSW && div_done)
			pos_q <= neg_q ? -div_quot[POS_W-1:0] : div_quot[POS_W-1:0];
		if (state_q == ST_YAW) begin
			e_q     <= e_new;
			ydiff_q <= ydiff_new;
			pacc_q  <= '0;
			yacc_q  <= '0;
		end
		if (state_q == ST_MUL && mul_cnt_q != 3'd0) begin
			if (mul_cnt_q <= 3'd3)
				pacc_q <= pacc_q + ACC_W'(mul_prod);
			else
				yacc_q <= yacc_q + ACC_W'(mul_prod);
		end
		if (state_q == ST_TRUNC) begin
			absc_q  <= (pabs > CORR_LIM) ? ABSC_W'(CORR_LIM) : pabs[ABSC_W-1:0];
			ycorr_q <= yt[CORR_W-1:0];
		end
		if (state_q == ST_FIN && out_free) begin
			out_left_q  <= mode_q ? ld : hold_d;
			out_right_q <= mode_q ? rd : hold_d;
			out_ref_q   <= !mode_q ?
				((pitch_q <= LEVEL_BAND && pitch_q >= -LEVEL_BAND) ? drive_angle_q : setpoint_q) :
				((pitch_q > fwd_limit_q || pitch_q < FALL_LIMIT) ? setpoint_q : held_ref_q);
			out_bal_q   <= !mode_q ? (pitch_q <= LEVEL_BAND && pitch_q >= -LEVEL_BAND) :
				!(pitch_q > fwd_limit_q || pitch_q < FALL_LIMIT);
			if (!mode_q)
				out_dir_q <= (pitch_q > LEVEL_BAND) ? DIR_FWD :
					(pitch_q < -LEVEL_BAND) ? DIR_BACK : DIR_STOP;
			else
				out_dir_q <= (pitch_q > 0) ? DIR_FWD : (pitch_q < 0) ? DIR_BACK : DIR_STOP;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_bal_q, out_ref_q, out_dir_q, out_right_q, out_left_q};

	// checks
	`BLFC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready, "input accepted while busy")
	`BLFC_ASSERT_SAME(a_left_range, clk, arst_n, m_tvalid, out_left_q >= 7'd45 && out_left_q <= 7'd115, "left duty out of range")
	`BLFC_ASSERT_SAME(a_right_range, clk, arst_n, m_tvalid, out_right_q >= 7'd45 && out_right_q <= 7'd115, "right duty out of range")
	`BLFC_ASSERT_SAME(a_mode_match, clk, arst_n, m_tvalid, out_bal_q == mode_q && out_ref_q == held_ref_q, "result disagrees with loop state")
endmodule
`default_nettype wire

// ----- hdl/blfc_div.sv -----
// unsigned divider for the line position, two quotient bits per cycle
// depends on blfc_pkg
`default_nettype none
module blfc_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire blfc_pkg::div_req_t            req,
	output logic                               done,
	output logic [blfc_pkg::DIV_NUM_W-1:0]     quot
);
	import blfc_pkg::*;

	localparam int STEPS = DIV_NUM_W / 2;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_NUM_W-1:0] quot_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;

	logic [DIV_DEN_W:0]   r1, r2, r1n, r2n;
	logic                 ge1, ge2;

	// two restoring steps
	always_comb begin
		r1  = {rem_q, num_q[DIV_NUM_W-1]};
		ge1 = r1 >= {1'b0, den_q};
		r1n = ge1 ? r1 - {1'b0, den_q} : r1;
		r2  = {r1n[DIV_DEN_W-1:0], num_q[DIV_NUM_W-2]};
		ge2 = r2 >= {1'b0, den_q};
		r2n = ge2 ? r2 - {1'b0, den_q} : r2;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= req.num;
			den_q  <= req.den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[DIV_NUM_W-3:0], 2'b00};
			rem_q  <= r2n[DIV_DEN_W-1:0];
			quot_q <= {quot_q[DIV_NUM_W-3:0], ge1, ge2};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule
`default_nettype wire

// ----- hdl/blfc_mul.sv -----
// shared signed multiplier with registered product
// depends on blfc_pkg
`default_nettype none
module blfc_mul (
	input  wire logic                                clk,
	input  wire logic signed [blfc_pkg::MUL_A_W-1:0] a,
	input  wire logic signed [blfc_pkg::MUL_B_W-1:0] b,
	output logic signed [blfc_pkg::PROD_W-1:0]       prod
);
	import blfc_pkg::*;

	logic signed [PROD_W-1:0] prod_q;

	// one product per cycle
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign prod = prod_q;
endmodule
`default_nettype wire
